### sv/dmlp_pkg.sv
package dmlp_pkg;

  // Widths fixed by the register and field definitions.
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned DEBOUNCE_W  = 8;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned STEP_W      = 4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALT_PERIOD   = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BURST_PERIOD = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FLASH_PERIOD = 4'd3;

  // Register values after reset.
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 8'd20;
  localparam logic [PERIOD_W-1:0]   ALT_RST      = 16'd250;
  localparam logic [PERIOD_W-1:0]   BURST_RST    = 16'd150;
  localparam logic [PERIOD_W-1:0]   FLASH_RST    = 16'd100;

  // Burst mode: red for the first half of the cycle, blue for the second.
  localparam logic [STEP_W-1:0] BURST_HALF  = 4'd6;
  localparam logic [STEP_W-1:0] BURST_STEPS = 4'd12;

  typedef enum logic [1:0] {
    MODE_ALT   = 2'd0,
    MODE_BURST = 2'd1,
    MODE_FLASH = 2'd2,
    MODE_OFF   = 2'd3
  } mode_t;

endpackage

### sv/debounced_mode_led_pattern_top.sv
// Debounced mode selector with a two-LED pattern generator. Each input item is
// one millisecond tick carrying the raw button level (0 pressed, 1 released),
// and each tick yields exactly one result item: the red and blue LED drive and
// the current mode (0 alternate, 1 burst, 2 flash, 3 off). The block takes one
// item per clock cycle, sustained, as long as results are taken. An item is
// held in the input register and its result is loaded into the output
// register when the item advances; the result is taken from that register. All
// per-tick work (debounce count, press detect, period compare, pattern
// step) is one pass of short logic between those two
// registers. While a result waits on a stalled consumer, the input register
// can still take one more item; after that the input stalls until the result
// is taken. Configuration registers must be written only while the block
// holds no items.
module debounced_mode_led_pattern_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [dmlp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dmlp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_button_level,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_red_on,
  output logic                                out_blue_on,
  output logic [1:0]                          out_mode_now
);

  // Compares are done at the wider of the counter and the period widths.
  localparam int unsigned CMP_W = (COUNT_WIDTH > dmlp_pkg::PERIOD_W) ?
                                  COUNT_WIDTH : dmlp_pkg::PERIOD_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Configuration registers.
  logic [dmlp_pkg::DEBOUNCE_W-1:0] debounce_ms_r;
  logic [dmlp_pkg::PERIOD_W-1:0]   alt_period_r;
  logic [dmlp_pkg::PERIOD_W-1:0]   burst_period_r;
  logic [dmlp_pkg::PERIOD_W-1:0]   flash_period_r;

  // Input register stage.
  logic s1_valid_r;
  logic s1_level_r;

  // Block state.
  logic                        prev_level_r,    prev_level_nxt;
  logic [COUNT_WIDTH-1:0]      stable_count_r,  stable_count_nxt;
  logic                        press_latched_r, press_latched_nxt;
  dmlp_pkg::mode_t             mode_r,          mode_nxt;
  logic [COUNT_WIDTH-1:0]      since_step_r,    since_step_nxt;
  logic [dmlp_pkg::STEP_W-1:0] step_index_r,    step_index_nxt;
  logic                        red_led_r,       red_led_nxt;
  logic                        blue_led_r,      blue_led_nxt;

  // Result register.
  logic       out_valid_r;
  logic       out_red_r;
  logic       out_blue_r;
  logic [1:0] out_mode_r;

  logic                        adv;
  logic [COUNT_WIDTH-1:0]      since_inc;
  logic [CMP_W-1:0]            since_cmp;
  logic [dmlp_pkg::STEP_W-1:0] step_inc;

  // The staged item moves on when the result register is empty or draining.
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;

  assign out_valid    = out_valid_r;
  assign out_red_on   = out_red_r;
  assign out_blue_on  = out_blue_r;
  assign out_mode_now = out_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r  <= dmlp_pkg::DEBOUNCE_RST;
      alt_period_r   <= dmlp_pkg::ALT_RST;
      burst_period_r <= dmlp_pkg::BURST_RST;
      flash_period_r <= dmlp_pkg::FLASH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dmlp_pkg::REG_DEBOUNCE_MS:  debounce_ms_r  <= cfg_wdata[dmlp_pkg::DEBOUNCE_W-1:0];
        dmlp_pkg::REG_ALT_PERIOD:   alt_period_r   <= cfg_wdata;
        dmlp_pkg::REG_BURST_PERIOD: burst_period_r <= cfg_wdata;
        dmlp_pkg::REG_FLASH_PERIOD: flash_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Per-tick update: button step first, then the pattern step with the
  // possibly advanced mode.
  always_comb begin
    prev_level_nxt    = prev_level_r;
    stable_count_nxt  = stable_count_r;
    press_latched_nxt = press_latched_r;
    mode_nxt          = mode_r;
    red_led_nxt       = red_led_r;
    blue_led_nxt      = blue_led_r;
    step_index_nxt    = step_index_r;
    since_inc         = '0;
    since_cmp         = '0;
    step_inc          = '0;

    if (s1_level_r != prev_level_r) begin
      prev_level_nxt   = s1_level_r;
      stable_count_nxt = '0;
    end else if (stable_count_r != COUNT_MAX) begin
      stable_count_nxt = stable_count_r + 1'b1;
    end

    if (stable_count_nxt > COUNT_WIDTH'(debounce_ms_r)) begin
      if (!s1_level_r) begin
        if (!press_latched_r) begin
          press_latched_nxt = 1'b1;
          mode_nxt          = dmlp_pkg::mode_t'(mode_r + 2'd1);
        end
      end else begin
        press_latched_nxt = 1'b0;
      end
    end

    since_inc      = (since_step_r == COUNT_MAX) ? since_step_r : since_step_r + 1'b1;
    since_step_nxt = since_inc;
    since_cmp      = CMP_W'(since_inc);

    case (mode_nxt)
      dmlp_pkg::MODE_ALT: begin
        if (since_cmp >= CMP_W'(alt_period_r)) begin
          since_step_nxt = '0;
          if (step_index_r == '0) begin
            red_led_nxt    = 1'b1;
            blue_led_nxt   = 1'b0;
            step_index_nxt = 4'd1;
          end else begin
            red_led_nxt    = 1'b0;
            blue_led_nxt   = 1'b1;
            step_index_nxt = '0;
          end
        end
      end
      dmlp_pkg::MODE_BURST: begin
        if (since_cmp >= CMP_W'(burst_period_r)) begin
          since_step_nxt = '0;
          // Red blinks in the first half, blue in the second; lit on even steps.
          if (step_index_r < dmlp_pkg::BURST_HALF) begin
            red_led_nxt = !step_index_r[0];
          end else if (step_index_r < dmlp_pkg::BURST_STEPS) begin
            blue_led_nxt = !step_index_r[0];
          end
          step_inc       = step_index_r + 1'b1;
          step_index_nxt = (step_inc >= dmlp_pkg::BURST_STEPS) ? '0 : step_inc;
        end
      end
      dmlp_pkg::MODE_FLASH: begin
        if (since_cmp >= CMP_W'(flash_period_r)) begin
          since_step_nxt = '0;
          if (step_index_r == '0) begin
            red_led_nxt    = 1'b1;
            blue_led_nxt   = 1'b1;
            step_index_nxt = 4'd1;
          end else begin
            red_led_nxt    = 1'b0;
            blue_led_nxt   = 1'b0;
            step_index_nxt = '0;
          end
        end
      end
      default: begin
        // Off mode: LEDs dark and the step restarts; the tick count keeps going.
        red_led_nxt    = 1'b0;
        blue_led_nxt   = 1'b0;
        step_index_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      prev_level_r    <= 1'b1;
      stable_count_r  <= '0;
      press_latched_r <= 1'b0;
      mode_r          <= dmlp_pkg::MODE_ALT;
      since_step_r    <= '0;
      step_index_r    <= '0;
      red_led_r       <= 1'b0;
      blue_led_r      <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r     <= 1'b1;
        prev_level_r    <= prev_level_nxt;
        stable_count_r  <= stable_count_nxt;
        press_latched_r <= press_latched_nxt;
        mode_r          <= mode_nxt;
        since_step_r    <= since_step_nxt;
        step_index_r    <= step_index_nxt;
        red_led_r       <= red_led_nxt;
        blue_led_r      <= blue_led_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_level_r <= in_button_level;
    end
    if (adv) begin
      out_red_r  <= red_led_nxt;
      out_blue_r <= blue_led_nxt;
      out_mode_r <= mode_nxt;
    end
  end

  // The input stage only stalls while it holds an item.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input stage");

  // The mode changes only when an item is processed.
  a_mode_only_on_item: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(mode_r))
    else $error("mode changed without an item");

  // One item advances the mode by at most one.
  a_mode_single_step: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (mode_r == $past(mode_r)) || (mode_r == $past(mode_r) + 2'd1))
    else $error("mode jumped by more than one");

  // The step index never leaves the burst cycle range.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_index_r < dmlp_pkg::BURST_STEPS)
    else $error("step index out of range");

  // In off mode a result never shows a lit LED.
  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_mode_r == dmlp_pkg::MODE_OFF)) |-> (!out_red_r && !out_blue_r))
    else $error("LED lit in off mode");

endmodule
